>>> sv/ansi_sgr_colour_parser_top_macros.svh
// Assertion helpers for the SGR colour parser.
`ifndef ANSI_SGR_COLOUR_PARSER_TOP_MACROS_SVH
`define ANSI_SGR_COLOUR_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASGR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/asgr_pkg.sv
package asgr_pkg;

    localparam int CHAR_W     = 9;
    localparam int ATTR_W     = 8;
    localparam int PARAM_W    = 10;
    localparam int ACC_W      = 14;
    localparam int MAX_PARAMS = 4;
    localparam int CNT_W      = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    localparam logic [CHAR_W-1:0]  CH_ESC    = 9'h01B;
    localparam logic [CHAR_W-1:0]  CH_LBRACK = 9'h05B;
    localparam logic [CHAR_W-1:0]  CH_SEMI   = 9'h03B;
    localparam logic [CHAR_W-1:0]  CH_M      = 9'h06D;
    localparam logic [CHAR_W-1:0]  CH_ZERO   = 9'h030;
    localparam logic [CHAR_W-1:0]  CH_NINE   = 9'h039;

    localparam logic [ATTR_W-1:0]  ATTR_RESET = 8'h07;
    localparam logic [PARAM_W-1:0] PARAM_SAT  = 10'd999;
    localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(MAX_PARAMS - 1);

    typedef enum logic [4:0] {
        S_NORMAL  = 5'b00001,
        S_ESCAPE  = 5'b00010,
        S_BRACKET = 5'b00100,
        S_PARAM   = 5'b01000,
        S_APPLY   = 5'b10000
    } t_state;

    // ANSI colour order to CGA colour order
    function automatic logic [2:0] cga_of_ansi(input logic [2:0] a);
        logic [2:0] c;
        unique case (a)
            3'd0: c = 3'd0;
            3'd1: c = 3'd4;
            3'd2: c = 3'd2;
            3'd3: c = 3'd6;
            3'd4: c = 3'd1;
            3'd5: c = 3'd5;
            3'd6: c = 3'd3;
            3'd7: c = 3'd7;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

>>> sv/asgr_sgr_unit.sv
module asgr_sgr_unit (
    input  logic [asgr_pkg::ATTR_W-1:0]  i_attr,
    input  logic [asgr_pkg::PARAM_W-1:0] i_code,
    output logic [asgr_pkg::ATTR_W-1:0]  o_attr
);
    import asgr_pkg::*;

    logic [PARAM_W-1:0] fg_off;
    logic [PARAM_W-1:0] bg_off;
    logic [PARAM_W-1:0] bfg_off;
    logic [PARAM_W-1:0] bbg_off;

    assign fg_off  = i_code - PARAM_W'(30);
    assign bg_off  = i_code - PARAM_W'(40);
    assign bfg_off = i_code - PARAM_W'(90);
    assign bbg_off = i_code - PARAM_W'(100);

    // Apply one SGR code; codes outside the known set leave the attribute alone.
    always_comb begin
        priority if (i_code == PARAM_W'(0)) begin
            o_attr = ATTR_RESET;
        end else if (i_code == PARAM_W'(1)) begin
            o_attr = i_attr | 8'h08;
        end else if (fg_off < PARAM_W'(8)) begin
            o_attr = {i_attr[7:4], 1'b0, cga_of_ansi(fg_off[2:0])};
        end else if (bg_off < PARAM_W'(8)) begin
            o_attr = {1'b0, cga_of_ansi(bg_off[2:0]), i_attr[3:0]};
        end else if (bfg_off < PARAM_W'(8)) begin
            o_attr = {i_attr[7:4], 1'b1, cga_of_ansi(bfg_off[2:0])};
        end else if (bbg_off < PARAM_W'(8)) begin
            o_attr = {1'b1, cga_of_ansi(bbg_off[2:0]), i_attr[3:0]};
        end else begin
            o_attr = i_attr;
        end
    end

endmodule

>>> sv/ansi_sgr_colour_parser_top.sv
// ANSI SGR colour parser.
// Input channel: i_in_valid / o_in_stall carry one console character per item
// (i_in_char, 9 bits, 256 = backspace). Output channel: o_out_valid / i_out_stall
// carry one displayed character per item with its text attribute (o_out_attr,
// foreground in the low nibble, background in the high nibble).
// Ordinary characters come out in the cycle after acceptance from an output
// register; a character can be taken every cycle while the receiver keeps
// i_out_stall low. Escape sequence characters give no output item.
// A terminating 'm' after parameters starts an apply sequence that runs the stored
// parameters one per cycle through a single SGR unit with o_in_stall high, so the
// item rate is one per cycle for text and no character is taken during an apply.
// While a finished item sits in the output register and the receiver stalls,
// o_in_stall is high and nothing is accepted; the held item stays unchanged.
// Synchronous active-low reset returns to plain text, attribute 0x07 (white on
// black), empties the output register. Parameter slots need no reset because
// each slot is written before it is read.
module ansi_sgr_colour_parser_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [asgr_pkg::CHAR_W-1:0] i_in_char,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [asgr_pkg::CHAR_W-1:0] o_out_char,
    output logic [asgr_pkg::ATTR_W-1:0] o_out_attr
);
    import asgr_pkg::*;

    t_state              r_state,     n_state;
    logic [ATTR_W-1:0]   r_attr,      n_attr;
    logic [CNT_W-1:0]    r_count,     n_count;
    logic [CNT_W-1:0]    r_apply_idx, n_apply_idx;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char,  n_out_char;
    logic [ATTR_W-1:0]   r_out_attr,  n_out_attr;
    logic [PARAM_W-1:0]  r_param [MAX_PARAMS];

    logic                in_acc;
    logic                out_busy;
    logic                is_digit;
    logic [3:0]          digit_val;
    logic [PARAM_W-1:0]  cur_param;
    logic [ACC_W-1:0]    acc_sum;
    logic [PARAM_W-1:0]  acc_sat;
    logic                param_we;
    logic [CNT_W-1:0]    param_wa;
    logic [PARAM_W-1:0]  param_wd;
    logic [PARAM_W-1:0]  apply_code;
    logic [ATTR_W-1:0]   apply_attr;

    // Hold the input while applying parameters or while the output item waits.
    assign out_busy   = r_out_valid && i_out_stall;
    assign o_in_stall = (r_state == S_APPLY) || out_busy;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign is_digit  = (i_in_char >= CH_ZERO) && (i_in_char <= CH_NINE);
    assign digit_val = 4'(i_in_char - CH_ZERO);

    // Decimal accumulate: param * 10 + digit, as two shifts and two adds.
    assign cur_param = r_param[r_count];
    assign acc_sum   = {1'b0, cur_param, 3'b000} + {3'b000, cur_param, 1'b0}
                     + ACC_W'(digit_val);
    assign acc_sat   = (acc_sum > ACC_W'(PARAM_SAT)) ? PARAM_SAT : acc_sum[PARAM_W-1:0];

    // Shared SGR unit, stepped by the apply sequencer.
    assign apply_code = r_param[r_apply_idx];

    asgr_sgr_unit u_sgr (
        .i_attr (r_attr),
        .i_code (apply_code),
        .o_attr (apply_attr)
    );

    always_comb begin
        n_state     = r_state;
        n_attr      = r_attr;
        n_count     = r_count;
        n_apply_idx = r_apply_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_char  = r_out_char;
        n_out_attr  = r_out_attr;
        param_we    = 1'b0;
        param_wa    = r_count;
        param_wd    = acc_sat;

        unique case (r_state)
            S_NORMAL: begin
                if (in_acc) begin
                    if (i_in_char == CH_ESC) begin
                        n_state = S_ESCAPE;
                        n_count = '0;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_char  = i_in_char;
                        n_out_attr  = r_attr;
                    end
                end
            end
            S_ESCAPE: begin
                if (in_acc) begin
                    n_state = (i_in_char == CH_LBRACK) ? S_BRACKET : S_NORMAL;
                end
            end
            S_BRACKET: begin
                if (in_acc) begin
                    priority if (is_digit) begin
                        param_we = 1'b1;
                        param_wa = '0;
                        param_wd = PARAM_W'(digit_val);
                        n_state  = S_PARAM;
                    end else if (i_in_char == CH_M) begin
                        n_attr  = ATTR_RESET;
                        n_state = S_NORMAL;
                    end else begin
                        n_state = S_NORMAL;
                    end
                end
            end
            S_PARAM: begin
                if (in_acc) begin
                    priority if (is_digit) begin
                        param_we = 1'b1;
                    end else if (i_in_char == CH_SEMI) begin
                        // Open the next slot cleared, or abort once all are used.
                        if (r_count == CNT_LAST) begin
                            n_state = S_NORMAL;
                        end else begin
                            n_count  = r_count + CNT_W'(1);
                            param_we = 1'b1;
                            param_wa = r_count + CNT_W'(1);
                            param_wd = '0;
                        end
                    end else if (i_in_char == CH_M) begin
                        n_apply_idx = '0;
                        n_state     = S_APPLY;
                    end else begin
                        n_state = S_NORMAL;
                    end
                end
            end
            S_APPLY: begin
                // Advance one parameter per cycle through slots 0 .. r_count.
                n_attr = apply_attr;
                if (r_apply_idx == r_count) begin
                    n_state = S_NORMAL;
                end else begin
                    n_apply_idx = r_apply_idx + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_NORMAL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_NORMAL;
            r_attr      <= ATTR_RESET;
            r_count     <= '0;
            r_apply_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_attr      <= n_attr;
            r_count     <= n_count;
            r_apply_idx <= n_apply_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_attr <= n_out_attr;
        if (param_we) begin
            r_param[param_wa] <= param_wd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_attr  = r_out_attr;

`include "ansi_sgr_colour_parser_top_macros.svh"

    `ASGR_ASSERT_NOW(a_apply_blocks_input, r_state == S_APPLY, o_in_stall,
        "input taken while applying parameters")
    `ASGR_ASSERT_NOW(a_apply_idx_in_range, r_state == S_APPLY, r_apply_idx <= r_count,
        "apply index passed the parameter count")
    `ASGR_ASSERT_NEXT(a_esc_enters_escape,
        in_acc && r_state == S_NORMAL && i_in_char == CH_ESC,
        r_state == S_ESCAPE && r_count == '0, "ESC did not open a sequence")
    `ASGR_ASSERT_NEXT(a_stalled_item_kept, out_busy, r_out_valid,
        "waiting output item was lost")

endmodule

>>> test/ansi_sgr_colour_parser_top_tb.sv
module ansi_sgr_colour_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asgr_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    // 'm' applies up to four slots one per cycle, then one output register
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_CHARS  = 1700;
    localparam int PHASES        = 4;
    localparam int PRINT_CAP     = 40;

    localparam logic [CHAR_W-1:0] CH_BS = 9'd256;

    // sender idle and receiver stall odds per phase, in percent
    localparam int SRC_IDLE_PCT [PHASES]  = '{0, 62, 0, 26};
    localparam int RCV_STALL_PCT [PHASES] = '{0, 0, 62, 26};

    // ANSI colour index to CGA colour index
    localparam logic [2:0] CGA_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    typedef enum logic [1:0] {
        TXT,
        ESC_SEEN,
        CSI_OPEN,
        IN_PARAM
    } t_parse;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
    } t_display;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              fixed;
        logic [ATTR_W-1:0] attr;
    } t_key_row;

    localparam int DIR_N = 34;

    // DUT ports; the inputs are known from time zero
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [CHAR_W-1:0] i_in_char   = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [CHAR_W-1:0] o_out_char;
    logic [ATTR_W-1:0] o_out_attr;

    // shadow copy of the parser state
    t_parse             phase_q;
    logic [PARAM_W-1:0] slot_q [MAX_PARAMS];
    logic [2:0]         slot_cnt_q;
    logic [ATTR_W-1:0]  attr_q;

    // characters that must still appear on the display side, oldest first
    t_display display_q [$];

    int src_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int chars_sent    = 0;
    int chars_shown   = 0;
    int sgr_sent      = 0;
    int mismatch_cnt  = 0;
    int cycle_cnt     = 0;

    t_key_row dir_rows [DIR_N];

    ansi_sgr_colour_parser_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_char  (i_in_char),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_char (o_out_char),
        .o_out_attr (o_out_attr)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Give up on a hang: the run cannot take this long even at full stall odds.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items outstanding", cycle_cnt,
                     display_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < PRINT_CAP) begin
            $display("%0t: %s", $realtime, msg);
        end
        mismatch_cnt++;
    endtask

    // Work out the attribute one SGR code leaves behind.
    function automatic logic [ATTR_W-1:0] sgr_attr(input logic [ATTR_W-1:0] a,
                                                   input logic [PARAM_W-1:0] p);
        int unsigned v;
        v = p;
        if (v == 0) return ATTR_RESET;
        if (v == 1) return a | 8'h08;
        if (v >= 30 && v <= 37) return {a[7:4], 1'b0, CGA_MAP[v - 30]};
        if (v >= 40 && v <= 47) return {1'b0, CGA_MAP[v - 40], a[3:0]};
        if (v >= 90 && v <= 97) return {a[7:4], 1'b1, CGA_MAP[v - 90]};
        if (v >= 100 && v <= 107) return {1'b1, CGA_MAP[v - 100], a[3:0]};
        return a;
    endfunction

    // Advance the shadow parser by one character; return 1 when it is displayed.
    function automatic bit parse_char(input logic [CHAR_W-1:0] c,
                                      output logic [ATTR_W-1:0] attr);
        bit          digit;
        logic [13:0] acc;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        attr  = attr_q;
        case (phase_q)
            TXT: begin
                if (c == CH_ESC) begin
                    phase_q    = ESC_SEEN;
                    slot_cnt_q = '0;
                    return 1'b0;
                end
                return 1'b1;
            end
            ESC_SEEN: begin
                phase_q = (c == CH_LBRACK) ? CSI_OPEN : TXT;
            end
            CSI_OPEN: begin
                if (digit && slot_cnt_q < MAX_PARAMS) begin
                    slot_q[slot_cnt_q[CNT_W-1:0]] = PARAM_W'(c - CH_ZERO);
                    phase_q                       = IN_PARAM;
                end else if (c == CH_M) begin
                    // bare ESC [ m
                    attr_q  = ATTR_RESET;
                    phase_q = TXT;
                end else begin
                    phase_q = TXT;
                end
            end
            default: begin
                if (slot_cnt_q >= MAX_PARAMS) begin
                    phase_q = TXT;
                end else if (digit) begin
                    acc = 14'(slot_q[slot_cnt_q[CNT_W-1:0]]) * 14'd10 + 14'(c - CH_ZERO);
                    slot_q[slot_cnt_q[CNT_W-1:0]] =
                        (acc > 14'(PARAM_SAT)) ? PARAM_SAT : PARAM_W'(acc);
                end else if (c == CH_SEMI) begin
                    // a ';' opens the next slot empty, or aborts past the last one
                    slot_cnt_q++;
                    if (slot_cnt_q >= MAX_PARAMS) phase_q = TXT;
                    else slot_q[slot_cnt_q[CNT_W-1:0]] = '0;
                end else if (c == CH_M) begin
                    slot_cnt_q++;
                    for (int k = 0; k < slot_cnt_q && k < MAX_PARAMS; k++) begin
                        attr_q = sgr_attr(attr_q, slot_q[k]);
                    end
                    phase_q = TXT;
                end else begin
                    phase_q = TXT;
                end
            end
        endcase
        return 1'b0;
    endfunction

    // Offer one character after a random gap and hold it until accepted.
    // Valid stays high on return so the next item can follow back to back.
    task automatic send_checked(input logic [CHAR_W-1:0] c, input logic fixed,
                                input logic [ATTR_W-1:0] fixed_attr);
        logic [ATTR_W-1:0] attr;
        bit                shown;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char  <= c;
        do @(posedge i_clk); while (o_in_stall);
        shown = parse_char(c, attr);
        if (shown) begin
            display_q.push_back('{ch: c, attr: fixed ? fixed_attr : attr});
        end
        chars_sent++;
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c);
        send_checked(c, 1'b0, '0);
    endtask

    task automatic send_number(input int unsigned v, input bit pad);
        string s;
        s = $sformatf("%0d", v);
        if (pad) send_char(CH_ZERO);
        for (int k = 0; k < s.len(); k++) begin
            send_char({1'b0, s[k]});
        end
    endtask

    // Mostly real colour codes, some unknown, some far past saturation.
    function automatic int unsigned pick_param();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return 30 + $urandom_range(7);
            3: return 40 + $urandom_range(7);
            4: return 90 + $urandom_range(7);
            5: return 100 + $urandom_range(7);
            6: return $urandom_range(120);
            7: return $urandom_range(99999);
            default: return 2 + $urandom_range(27);
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] text_char();
        logic [CHAR_W-1:0] c;
        do begin
            c = ($urandom_range(1) == 0) ? CHAR_W'($urandom_range(126, 32))
                                         : CHAR_W'($urandom_range(511));
        end while (c == CH_ESC);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] noise_char();
        case ($urandom_range(3))
            0: return CH_ESC;
            1: return CH_BS;
            default: return CHAR_W'($urandom_range(511));
        endcase
    endfunction

    // Well-formed ESC [ ... m with random content; sometimes one or two slots too many.
    task automatic send_sgr();
        int unsigned n;
        n = $urandom_range(MAX_PARAMS);
        if ($urandom_range(11) == 0) n = MAX_PARAMS + 1 + $urandom_range(1);
        send_char(CH_ESC);
        send_char(CH_LBRACK);
        for (int k = 0; k < n; k++) begin
            if (k > 0) send_char(CH_SEMI);
            // leave some slots empty; an empty first slot aborts the sequence unless it is the only one
            if ($urandom_range(9) != 0 || (k == 0 && $urandom_range(3) != 0)) begin
                send_number(pick_param(), $urandom_range(7) == 0);
            end
        end
        send_char(CH_M);
        sgr_sent++;
    endtask

    // Sequences cut short or derailed by a stray character.
    task automatic send_broken();
        send_char(CH_ESC);
        case ($urandom_range(2))
            0: send_char(noise_char());
            1: begin
                send_char(CH_LBRACK);
                send_number(pick_param(), 1'b0);
                send_char(noise_char());
            end
            default: begin
                send_char(CH_LBRACK);
                send_char(noise_char());
            end
        endcase
    endtask

    // Receiver: stall at random, independent of valid.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    // Check every displayed character against the oldest one still owed.
    always @(posedge i_clk) begin : display_check
        t_display want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (display_q.size() == 0) begin
                report_mismatch($sformatf("unexpected char %03h attr %02h",
                                          o_out_char, o_out_attr));
            end else begin
                want = display_q.pop_front();
                if (o_out_char !== want.ch) begin
                    report_mismatch($sformatf("char %03h, want %03h", o_out_char, want.ch));
                end
                if (o_out_attr !== want.attr) begin
                    report_mismatch($sformatf("attr %02h on char %03h, want %02h",
                                              o_out_attr, want.ch, want.attr));
                end
                chars_shown++;
            end
        end
    end

    initial begin
        int target;
        int pick;

        // Directed rows: code extremes after reset, saturation, empty slot, bold,
        // bright background, ';' straight after ESC [, too many slots, a non-'['
        // after ESC, and bare ESC [ m.
        dir_rows = '{
            '{9'd0,          1'b1, ATTR_RESET},
            '{9'd511,        1'b1, ATTR_RESET},
            '{CH_BS,         1'b1, ATTR_RESET},
            '{CH_ESC,        1'b0, 8'h00},
            '{CH_LBRACK,     1'b0, 8'h00},
            '{{1'b0, "9"},   1'b0, 8'h00},
            '{{1'b0, "9"},   1'b0, 8'h00},
            '{{1'b0, "9"},   1'b0, 8'h00},
            '{{1'b0, "9"},   1'b0, 8'h00},
            '{CH_SEMI,       1'b0, 8'h00},
            '{CH_SEMI,       1'b0, 8'h00},
            '{{1'b0, "1"},   1'b0, 8'h00},
            '{CH_SEMI,       1'b0, 8'h00},
            '{{1'b0, "1"},   1'b0, 8'h00},
            '{{1'b0, "0"},   1'b0, 8'h00},
            '{{1'b0, "4"},   1'b0, 8'h00},
            '{CH_M,          1'b0, 8'h00},
            '{CH_ESC,        1'b0, 8'h00},
            '{CH_LBRACK,     1'b0, 8'h00},
            '{CH_SEMI,       1'b0, 8'h00},
            '{CH_ESC,        1'b0, 8'h00},
            '{CH_LBRACK,     1'b0, 8'h00},
            '{{1'b0, "1"},   1'b0, 8'h00},
            '{CH_SEMI,       1'b0, 8'h00},
            '{CH_SEMI,       1'b0, 8'h00},
            '{CH_SEMI,       1'b0, 8'h00},
            '{CH_SEMI,       1'b0, 8'h00},
            '{{1'b0, "C"},   1'b0, 8'h00},
            '{CH_ESC,        1'b0, 8'h00},
            '{{1'b0, "x"},   1'b0, 8'h00},
            '{CH_ESC,        1'b0, 8'h00},
            '{CH_LBRACK,     1'b0, 8'h00},
            '{CH_M,          1'b0, 8'h00},
            '{{1'b0, "D"},   1'b1, ATTR_RESET}
        };

        // shadow state after reset
        phase_q    = TXT;
        slot_cnt_q = '0;
        attr_q     = ATTR_RESET;
        for (int k = 0; k < MAX_PARAMS; k++) slot_q[k] = '0;

        // hold reset, then release it once for the whole run
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            src_idle_pct  = SRC_IDLE_PCT[ph];
            rcv_stall_pct = RCV_STALL_PCT[ph];
            if (ph == 0) begin
                foreach (dir_rows[r]) begin
                    send_checked(dir_rows[r].ch, dir_rows[r].fixed, dir_rows[r].attr);
                end
            end
            // random bursts: colour sequences, broken sequences, runs of text
            target = chars_sent + RANDOM_CHARS / PHASES;
            while (chars_sent < target) begin
                pick = $urandom_range(99);
                if (pick < 50) send_sgr();
                else if (pick < 62) send_broken();
                repeat (1 + $urandom_range(4)) send_char(text_char());
            end
        end

        // drop valid, drain what is owed, then let any late output show up
        i_in_valid <= 1'b0;
        while (display_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d characters sent in %0d cycles, %0d SGR sequences among them",
                 chars_sent, cycle_cnt, sgr_sent);
        $display("%0d displayed characters checked, %0d mismatches", chars_shown,
                 mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/asgr_pkg.sv
sv/asgr_sgr_unit.sv
sv/ansi_sgr_colour_parser_top.sv
test/ansi_sgr_colour_parser_top_tb.sv
